FILE: design/lcar_pkg.sv
`timescale 1ns / 1ps
package lcar_pkg;

    localparam int COUNT_W    = 8;
    localparam int TARE_W     = 25;
    localparam int SLOPE_W    = 32;
    localparam int AVG_W      = 25;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE        = 2'd2;

    localparam logic [COUNT_W-1:0]        SAMPLE_COUNT_RST = 8'd20;
    localparam logic signed [TARE_W-1:0]  TARE_OFFSET_RST  = 25'sd0;
    localparam logic signed [SLOPE_W-1:0] SLOPE_RST        = 32'sd16777216;

    typedef struct packed {
        logic sck;
        logic word_done;
    } lcar_ctl_t;

endpackage

FILE: design/lcar_front.sv
`timescale 1ns / 1ps
module lcar_front #(
    parameter int DATA_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic                  dout_level,
    output lcar_pkg::lcar_ctl_t   ctl,
    output logic [DATA_BITS-1:0]  word
);

    localparam int BC_W = $clog2(DATA_BITS + 2);
    localparam logic [BC_W-1:0] LAST_BIT = BC_W'(DATA_BITS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [BC_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [BC_W-1:0]      bit_cnt_inc;
    logic [DATA_BITS-1:0] shift_reg, shift_next;

    always_comb begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        bit_cnt_inc  = bit_cnt_reg + 1'b1;
        ctl          = '0;
        unique case (phase_reg)
            PH_HIGH: begin
                ctl.sck    = 1'b1;
                phase_next = PH_LOW;
            end
            PH_LOW: begin
                bit_cnt_next = bit_cnt_inc;
                if (bit_cnt_inc <= LAST_BIT) begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout_level};
                end
                if (bit_cnt_inc > LAST_BIT) begin
                    ctl.word_done = 1'b1;
                    phase_next    = PH_IDLE;
                end else begin
                    phase_next = PH_HIGH;
                end
            end
            PH_IDLE: begin
                if (!dout_level) begin
                    bit_cnt_next = '0;
                    shift_next   = '0;
                    phase_next   = PH_HIGH;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign word = shift_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

FILE: design/lcar_queue.sv
`timescale 1ns / 1ps
module lcar_queue #(
    parameter int WIDTH = 26
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: design/lcar_back.sv
`timescale 1ns / 1ps
module lcar_back #(
    parameter int DATA_BITS       = 24,
    parameter int SLOPE_FRAC_BITS = 24
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    q_empty,
    input  lcar_pkg::lcar_ctl_t                     q_ctl,
    input  logic [DATA_BITS-1:0]                    q_word,
    output logic                                    q_pop,
    input  logic [lcar_pkg::COUNT_W-1:0]            sample_count,
    input  logic signed [lcar_pkg::TARE_W-1:0]      tare_offset,
    input  logic signed [lcar_pkg::SLOPE_W-1:0]     slope,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic                                    m_sck_level,
    output logic                                    m_sample_done,
    output logic signed [lcar_pkg::AVG_W-1:0]       m_average_value,
    output logic signed [lcar_pkg::WEIGHT_W-1:0]    m_weight
);

    localparam int CW      = lcar_pkg::COUNT_W;
    localparam int AW      = lcar_pkg::AVG_W;
    localparam int WW      = lcar_pkg::WEIGHT_W;
    localparam int SUM_W   = DATA_BITS + CW + 1;
    localparam int QW      = (SUM_W > AW + 1) ? SUM_W : AW + 1;
    localparam int STEP_W  = $clog2(QW + 1);
    localparam int DIFF_W  = AW + 1;
    localparam int PROD_W  = lcar_pkg::SLOPE_W + DIFF_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [QW-1:0]            mag_reg, mag_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     neg_reg, neg_next;
    logic                     sck_reg, sck_next;
    logic signed [AW-1:0]     avg_reg, avg_next;
    logic signed [WW-1:0]     weight_reg, weight_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_sck_reg, out_sck_next;
    logic                     out_done_reg, out_done_next;
    logic signed [AW-1:0]     out_avg_reg, out_avg_next;
    logic signed [WW-1:0]     out_weight_reg, out_weight_next;

    logic [CW-1:0]            n_eff;
    logic [CW-1:0]            cnt_inc;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [QW-1:0]     sum_q;
    logic [CW:0]              rem_shift;
    logic                     q_bit;
    logic signed [QW-1:0]     quot;
    logic signed [AW-1:0]     avg_sat;
    logic signed [PROD_W-1:0] shifted;
    logic signed [WW-1:0]     weight_sat;
    logic                     out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign n_eff    = (sample_count == '0) ? CW'(1) : sample_count;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign sum_add  = sum_reg - SUM_W'(signed'(q_word));
    assign sum_q    = QW'(sum_add);

    assign rem_shift = {rem_reg, mag_reg[QW-1]};
    assign q_bit     = (rem_shift >= {1'b0, n_eff});

    assign quot = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);

    always_comb begin
        if ((&quot[QW-1:AW-1]) || !(|quot[QW-1:AW-1])) begin
            avg_sat = AW'(quot);
        end else if (quot[QW-1]) begin
            avg_sat = {1'b1, {(AW-1){1'b0}}};
        end else begin
            avg_sat = {1'b0, {(AW-1){1'b1}}};
        end
    end

    assign shifted = prod_reg >>> SLOPE_FRAC_BITS;

    always_comb begin
        if ((&shifted[PROD_W-1:WW-1]) || !(|shifted[PROD_W-1:WW-1])) begin
            weight_sat = WW'(shifted);
        end else if (shifted[PROD_W-1]) begin
            weight_sat = {1'b1, {(WW-1){1'b0}}};
        end else begin
            weight_sat = {1'b0, {(WW-1){1'b1}}};
        end
    end

    always_comb begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        sck_next        = sck_reg;
        avg_next        = avg_reg;
        weight_next     = weight_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        q_pop           = 1'b0;
        out_valid_next  = out_valid_reg && !m_ready;
        out_sck_next    = out_sck_reg;
        out_done_next   = out_done_reg;
        out_avg_next    = out_avg_reg;
        out_weight_next = out_weight_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    if (q_ctl.word_done && (cnt_inc >= n_eff)) begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        neg_next   = sum_q[QW-1];
                        mag_next   = sum_q[QW-1] ? QW'(-sum_q) : QW'(sum_q);
                        rem_next   = '0;
                        step_next  = STEP_W'(QW);
                        sck_next   = q_ctl.sck;
                        state_next = ST_DIV;
                    end else begin
                        if (q_ctl.word_done) begin
                            sum_next = sum_add;
                            cnt_next = cnt_inc;
                        end
                        out_valid_next  = 1'b1;
                        out_sck_next    = q_ctl.sck;
                        out_done_next   = 1'b0;
                        out_avg_next    = avg_reg;
                        out_weight_next = weight_reg;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? CW'(rem_shift - {1'b0, n_eff}) : rem_shift[CW-1:0];
                mag_next  = {mag_reg[QW-2:0], q_bit};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                avg_next   = avg_sat;
                diff_next  = DIFF_W'(avg_sat) - DIFF_W'(tare_offset);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_W'(slope) * PROD_W'(diff_reg);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    weight_next     = weight_sat;
                    out_valid_next  = 1'b1;
                    out_sck_next    = sck_reg;
                    out_done_next   = 1'b1;
                    out_avg_next    = avg_reg;
                    out_weight_next = weight_sat;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            avg_reg       <= '0;
            weight_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            avg_reg       <= avg_next;
            weight_reg    <= weight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg        <= mag_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        neg_reg        <= neg_next;
        sck_reg        <= sck_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        out_sck_reg    <= out_sck_next;
        out_done_reg   <= out_done_next;
        out_avg_reg    <= out_avg_next;
        out_weight_reg <= out_weight_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_sck_level     = out_sck_reg;
    assign m_sample_done   = out_done_reg;
    assign m_average_value = out_avg_reg;
    assign m_weight        = out_weight_reg;

endmodule

FILE: design/load_cell_adc_reader_averager.sv
`timescale 1ns / 1ps
// Channel  | Ports                                               | Direction
// ---------+-----------------------------------------------------+----------
// s_       | s_valid, s_ready, s_dout_level                      | in
// m_       | m_valid, m_ready, m_sck_level, m_sample_done,       | out
//          | m_average_value, m_weight                           |
// cfg_     | cfg_wr_en, cfg_index, cfg_wdata                     | in
//
// An ordinary tick's result passes through the queue and then the output register; the front runs up to
// two ticks ahead of the back.
// The tick that closes an average passes a one-bit-per-cycle restoring divider, then saturate,
// multiply and output stages, before its result shows.
// Synchronous active-low reset clears control state and loads register defaults.
// Either side may stall independently; the two-entry queue and output register decouple them.
module load_cell_adc_reader_averager #(
    parameter int DATA_BITS       = 24,
    parameter int SLOPE_FRAC_BITS = 24
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_dout_level,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_sck_level,
    output logic                                    m_sample_done,
    output logic signed [lcar_pkg::AVG_W-1:0]       m_average_value,
    output logic signed [lcar_pkg::WEIGHT_W-1:0]    m_weight,
    input  logic                                    cfg_wr_en,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int QUEUE_W = DATA_BITS + 2;

    logic [lcar_pkg::COUNT_W-1:0]        sample_count_reg;
    logic signed [lcar_pkg::TARE_W-1:0]  tare_offset_reg;
    logic signed [lcar_pkg::SLOPE_W-1:0] slope_reg;

    logic                  in_fire;
    lcar_pkg::lcar_ctl_t   front_ctl;
    logic [DATA_BITS-1:0]  front_word;
    logic                  q_full, q_empty, q_pop;
    logic [QUEUE_W-1:0]    q_head;
    lcar_pkg::lcar_ctl_t   q_ctl;
    logic [DATA_BITS-1:0]  q_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= lcar_pkg::SAMPLE_COUNT_RST;
            tare_offset_reg  <= lcar_pkg::TARE_OFFSET_RST;
            slope_reg        <= lcar_pkg::SLOPE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcar_pkg::CFG_SAMPLE_COUNT: begin
                    sample_count_reg <= cfg_wdata[lcar_pkg::COUNT_W-1:0];
                end
                lcar_pkg::CFG_TARE_OFFSET: begin
                    tare_offset_reg <= cfg_wdata[lcar_pkg::TARE_W-1:0];
                end
                lcar_pkg::CFG_SLOPE: begin
                    slope_reg <= cfg_wdata[lcar_pkg::SLOPE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    lcar_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .dout_level (s_dout_level),
        .ctl        (front_ctl),
        .word       (front_word)
    );

    lcar_queue #(
        .WIDTH (QUEUE_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data ({front_ctl, front_word}),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    assign q_ctl  = lcar_pkg::lcar_ctl_t'(q_head[QUEUE_W-1:DATA_BITS]);
    assign q_word = q_head[DATA_BITS-1:0];

    lcar_back #(
        .DATA_BITS       (DATA_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_ctl           (q_ctl),
        .q_word          (q_word),
        .q_pop           (q_pop),
        .sample_count    (sample_count_reg),
        .tare_offset     (tare_offset_reg),
        .slope           (slope_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_sck_level     (m_sck_level),
        .m_sample_done   (m_sample_done),
        .m_average_value (m_average_value),
        .m_weight        (m_weight)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int     DATA_BITS       = 24;
    localparam int     SLOPE_FRAC_BITS = 24;
    localparam int     RAND_ITEMS      = 320;
    localparam int     LIMIT           = 1000000;
    localparam int     COUNT_W         = lcar_pkg::COUNT_W;
    localparam int     TARE_W          = lcar_pkg::TARE_W;
    localparam int     SLOPE_W         = lcar_pkg::SLOPE_W;
    localparam int     AVG_W           = lcar_pkg::AVG_W;
    localparam int     WEIGHT_W        = lcar_pkg::WEIGHT_W;
    localparam int     CFG_IDX_W       = lcar_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W      = lcar_pkg::CFG_DATA_W;
    localparam longint AVG_HI          = 64'sd16777215;
    localparam longint AVG_LO          = -64'sd16777216;
    localparam longint WGT_HI          = 64'sd2147483647;
    localparam longint WGT_LO          = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [1:0] RD_IDLE = 2'd0;
    localparam logic [1:0] RD_HIGH = 2'd1;
    localparam logic [1:0] RD_LOW  = 2'd2;

    typedef struct packed {
        logic                       sck;
        logic                       done;
        logic signed [AVG_W-1:0]    avg;
        logic signed [WEIGHT_W-1:0] wgt;
    } tick_res_t;

    typedef struct {
        bit                        wr;
        logic [COUNT_W-1:0]        count;
        logic signed [TARE_W-1:0]  tare;
        logic signed [SLOPE_W-1:0] slope;
        int                        idle_n;
        int                        conv_n;
        logic [DATA_BITS-1:0]      word_a;
        logic [DATA_BITS-1:0]      word_b;
        bit                        typed;
        tick_res_t                 res;
    } dir_row_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic                       s_dout_level    = 1'b1;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic                       m_sck_level;
    logic                       m_sample_done;
    logic signed [AVG_W-1:0]    m_average_value;
    logic signed [WEIGHT_W-1:0] m_weight;
    logic                       cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index       = lcar_pkg::CFG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0]      cfg_wdata       = '0;

    load_cell_adc_reader_averager #(
        .DATA_BITS      (DATA_BITS),
        .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dout_level   (s_dout_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sck_level    (m_sck_level),
        .m_sample_done  (m_sample_done),
        .m_average_value(m_average_value),
        .m_weight       (m_weight),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // reader state mirror
    logic [COUNT_W-1:0]        cfg_count = lcar_pkg::SAMPLE_COUNT_RST;
    logic signed [TARE_W-1:0]  cfg_tare  = lcar_pkg::TARE_OFFSET_RST;
    logic signed [SLOPE_W-1:0] cfg_slope = lcar_pkg::SLOPE_RST;
    logic [1:0]                rd_phase  = RD_IDLE;
    int                        bit_cnt   = 0;
    logic [DATA_BITS-1:0]      shreg     = '0;
    logic [COUNT_W-1:0]        taken     = '0;
    longint                    acc       = 0;
    logic                      sck_q     = 1'b0;
    logic signed [AVG_W-1:0]    last_avg = '0;
    logic signed [WEIGHT_W-1:0] last_wgt = '0;

    tick_res_t pending_ticks[$];
    bit        quiet         = 1'b0;
    int        n_sent        = 0;
    int        dir_items     = 0;
    int        ticks_checked = 0;
    int        averages_seen = 0;
    int        cfg_writes    = 0;
    int        mismatch_cnt  = 0;
    int        cycle_cnt     = 0;

    dir_row_t dir_rows [15] = '{
        // after reset: idle, outputs cleared
        '{1'b0, 8'd0, 25'sd0, 32'sd0, 3, 0, 24'h000000, 24'h000000, 1'b1,
          '{1'b0, 1'b0, 25'sd0, 32'sd0}},
        '{1'b1, 8'd1, 25'sd0, 32'sd16777216, 0, 1, 24'h800000, 24'h800000, 1'b1,
          '{1'b0, 1'b1, 25'sd8388608, 32'sd8388608}},
        '{1'b1, 8'd1, 25'sd0, 32'sd16777216, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
          '{1'b0, 1'b1, 25'sd1, 32'sd1}},
        // half slope on a negative reading floors
        '{1'b1, 8'd1, 25'sd0, 32'h00800000, 0, 1, 24'h000001, 24'h000001, 1'b1,
          '{1'b0, 1'b1, -25'sd1, -32'sd1}},
        // divide truncates toward zero
        '{1'b1, 8'd2, 25'sd0, 32'sd16777216, 0, 2, 24'h000000, 24'h000001, 1'b1,
          '{1'b0, 1'b1, 25'sd0, 32'sd0}},
        // zero count acts as one
        '{1'b1, 8'd0, 25'sd0, 32'sd16777216, 0, 1, 24'h000010, 24'h000010, 1'b1,
          '{1'b0, 1'b1, -25'sd16, -32'sd16}},
        '{1'b1, 8'd1, -25'sd8388608, 32'h80000000, 0, 1, 24'h800000, 24'h800000, 1'b1,
          '{1'b0, 1'b1, 25'sd8388608, 32'h80000000}},
        '{1'b1, 8'd1, -25'sd8388608, 32'h7FFFFFFF, 0, 1, 24'h800000, 24'h800000, 1'b1,
          '{1'b0, 1'b1, 25'sd8388608, 32'h7FFFFFFF}},
        // weight saturation, both directions
        '{1'b1, 8'd1, 25'h1000000, 32'h7FFFFFFF, 0, 1, 24'h800000, 24'h800000, 1'b1,
          '{1'b0, 1'b1, 25'sd8388608, 32'h7FFFFFFF}},
        '{1'b1, 8'd1, 25'h1000000, 32'h80000000, 0, 1, 24'h800000, 24'h800000, 1'b1,
          '{1'b0, 1'b1, 25'sd8388608, 32'h80000000}},
        '{1'b1, 8'd1, 25'sd16777215, 32'h7FFFFFFF, 0, 1, 24'h7FFFFF, 24'h7FFFFF, 1'b1,
          '{1'b0, 1'b1, -25'sd8388607, 32'h80000000}},
        // partial run at the largest count, then lower it
        '{1'b1, 8'd255, 25'sd0, 32'sd16777216, 0, 2, 24'hFFFFFF, 24'hFFFFFF, 1'b0,
          '{1'b0, 1'b0, 25'sd0, 32'sd0}},
        '{1'b1, 8'd1, 25'sd0, 32'sd16777216, 0, 1, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
          '{1'b0, 1'b1, 25'sd3, 32'sd3}},
        '{1'b1, 8'd3, 25'sd100, 32'h01800000, 1, 3, 24'h123456, 24'hABCDEF, 1'b0,
          '{1'b0, 1'b0, 25'sd0, 32'sd0}},
        '{1'b1, 8'd2, -25'sd77, 32'hFF000000, 0, 2, 24'h5A5A5A, 24'hA5A5A5, 1'b0,
          '{1'b0, 1'b0, 25'sd0, 32'sd0}}
    };

    function automatic tick_res_t step_reader(input logic lvl);
        tick_res_t r;
        longint    word;
        longint    n;
        longint    avg;
        longint    prod;
        longint    w;
        r.done = 1'b0;
        case (rd_phase)
            RD_HIGH: begin
                sck_q    = 1'b1;
                rd_phase = RD_LOW;
            end
            RD_LOW: begin
                sck_q   = 1'b0;
                bit_cnt = bit_cnt + 1;
                if (bit_cnt <= DATA_BITS) begin
                    shreg = {shreg[DATA_BITS-2:0], lvl};
                end
                if (bit_cnt >= DATA_BITS + 1) begin
                    word  = longint'($signed(shreg));
                    word  = -word;
                    n     = (cfg_count == 0) ? 64'sd1 : longint'(cfg_count);
                    acc   = acc + word;
                    taken = taken + 1'b1;
                    if (longint'(taken) >= n) begin
                        avg = acc / n;
                        if (avg < AVG_LO) avg = AVG_LO;
                        if (avg > AVG_HI) avg = AVG_HI;
                        prod = longint'(cfg_slope) * (avg - longint'(cfg_tare));
                        w    = prod >>> SLOPE_FRAC_BITS;
                        if (w > WGT_HI) w = WGT_HI;
                        if (w < WGT_LO) w = WGT_LO;
                        last_avg = avg[AVG_W-1:0];
                        last_wgt = w[WEIGHT_W-1:0];
                        acc      = 0;
                        taken    = '0;
                        r.done   = 1'b1;
                    end
                    rd_phase = RD_IDLE;
                end else begin
                    rd_phase = RD_HIGH;
                end
            end
            default: begin
                sck_q = 1'b0;
                if (!lvl) begin
                    bit_cnt  = 0;
                    shreg    = '0;
                    rd_phase = RD_HIGH;
                end
            end
        endcase
        r.sck = sck_q;
        r.avg = last_avg;
        r.wgt = last_wgt;
        return r;
    endfunction

    task automatic send_tick(input logic lvl, input bit typed = 1'b0,
                             input tick_res_t want = '0);
        int        gap;
        tick_res_t pred;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_dout_level = lvl;
        do @(posedge aclk); while (!s_ready);
        pred = step_reader(lvl);
        pending_ticks.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // one full readout: optional idle highs, start low, then a clock pulse per data bit and one more to end it
    task automatic send_conversion(input logic [DATA_BITS-1:0] word, input int idle_n,
                                   input bit typed, input tick_res_t want);
        while (rd_phase != RD_IDLE) send_tick(1'($urandom_range(0, 1)));
        repeat (idle_n) send_tick(1'b1);
        send_tick(1'b0);
        for (int p = 1; p <= DATA_BITS + 1; p++) begin
            send_tick(1'($urandom_range(0, 1)));
            if (p <= DATA_BITS) begin
                send_tick(word[DATA_BITS-p]);
            end else begin
                send_tick(1'($urandom_range(0, 1)), typed, want);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            lcar_pkg::CFG_SAMPLE_COUNT: cfg_count = data[COUNT_W-1:0];
            lcar_pkg::CFG_TARE_OFFSET:  cfg_tare  = data[TARE_W-1:0];
            lcar_pkg::CFG_SLOPE:        cfg_slope = data[SLOPE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic signed [TARE_W-1:0] tare,
                              input logic signed [SLOPE_W-1:0] slope);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        write_reg(lcar_pkg::CFG_SAMPLE_COUNT, {junk[31:8], cnt});
        write_reg(lcar_pkg::CFG_TARE_OFFSET, {junk[6:0], tare});
        write_reg(lcar_pkg::CFG_SLOPE, slope);
        write_reg(CFG_UNUSED, $urandom);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("load_cell_adc_reader_averager regression: fail");
            $finish;
        end
    end

    initial begin : result_side
        int        stall;
        tick_res_t got;
        tick_res_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_sck_level, m_sample_done, m_average_value, m_weight};
            ticks_checked++;
            if (got.done) averages_seen++;
            if (pending_ticks.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected transfer: sck=%0b done=%0b avg=%0d wgt=%0d",
                             got.sck, got.done, got.avg, got.wgt);
                end
            end else begin
                want = pending_ticks.pop_front();
                if (got.sck !== want.sck || got.done !== want.done ||
                    got.avg !== want.avg || got.wgt !== want.wgt) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("tick %0d: expected sck=%0b done=%0b avg=%0d wgt=%0d",
                                 ticks_checked, want.sck, want.done, want.avg, want.wgt);
                        $display("tick %0d:      got sck=%0b done=%0b avg=%0d wgt=%0d",
                                 ticks_checked, got.sck, got.done, got.avg, got.wgt);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [COUNT_W-1:0]        cnt;
        logic signed [TARE_W-1:0]  tare;
        logic signed [SLOPE_W-1:0] slope;
        logic [DATA_BITS-1:0]      word;
        int                        nconv;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (dir_rows[i].wr) begin
                set_config(dir_rows[i].count, dir_rows[i].tare, dir_rows[i].slope);
            end
            if (dir_rows[i].conv_n == 0) begin
                repeat (dir_rows[i].idle_n - 1) send_tick(1'b1);
                send_tick(1'b1, dir_rows[i].typed, dir_rows[i].res);
            end else begin
                for (int c = 0; c < dir_rows[i].conv_n; c++) begin
                    send_conversion((c % 2) ? dir_rows[i].word_b : dir_rows[i].word_a,
                                    (c == 0) ? dir_rows[i].idle_n : int'($urandom_range(0, 1)),
                                    dir_rows[i].typed && (c == dir_rows[i].conv_n - 1),
                                    dir_rows[i].res);
                end
            end
        end
        dir_items = n_sent;

        while (n_sent - dir_items < RAND_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       cnt = 8'd0;
                1, 2, 3, 4: cnt = 8'd1;
                5, 6, 7: cnt = COUNT_W'($urandom_range(2, 4));
                8:       cnt = COUNT_W'($urandom_range(5, 8));
                default: cnt = COUNT_W'($urandom_range(9, 255));
            endcase
            case ($urandom_range(0, 6))
                0:       tare = 25'sd0;
                1:       tare = TARE_W'($urandom_range(0, 2000) - 1000);
                2:       tare = -25'sd8388608;
                3:       tare = 25'sd8388608;
                4:       tare = 25'h1000000;
                5:       tare = 25'sd16777215;
                default: tare = TARE_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       slope = lcar_pkg::SLOPE_RST;
                1:       slope = 32'h80000000;
                2:       slope = 32'h7FFFFFFF;
                3:       slope = SLOPE_W'($urandom_range(0, 32'h04000000) - 32'h02000000);
                default: slope = SLOPE_W'($urandom);
            endcase
            set_config(cnt, tare, slope);
            nconv = $urandom_range(1, 5);
            repeat (nconv) begin
                // noise: random line levels, often starting reads at odd moments
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 40)) send_tick(1'($urandom_range(0, 1)));
                end
                case ($urandom_range(0, 7))
                    0:       word = 24'h800000;
                    1:       word = 24'h7FFFFF;
                    2:       word = 24'h000000;
                    3:       word = 24'hFFFFFF;
                    4:       word = DATA_BITS'($urandom_range(0, 64) - 32);
                    default: word = DATA_BITS'($urandom);
                endcase
                send_conversion(word, int'($urandom_range(0, 3)), 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("ran %0d ticks (%0d directed), %0d averages completed, %0d register writes",
                 n_sent, dir_items, averages_seen, cfg_writes);
        $display("%0d results checked, %0d mismatches", ticks_checked, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_ticks.size() == 0) begin
            $display("load_cell_adc_reader_averager regression: pass");
        end else begin
            $display("load_cell_adc_reader_averager regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/lcar_pkg.sv
design/lcar_front.sv
design/lcar_queue.sv
design/lcar_back.sv
design/load_cell_adc_reader_averager.sv
tb/sv/tb_top.sv
